/* design/enms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package enms_pkg;

  // Line buffer depth and the fixed field widths.
  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned LineAw     = $clog2(MaxWidth);
  localparam int unsigned MagW       = 8;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned ColW       = 10;
  localparam int unsigned RowW       = 12;
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 12;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned OutDepth   = 3;
  localparam int unsigned OutPtrW    = $clog2(OutDepth);
  localparam int unsigned OutCntW    = $clog2(OutDepth + 1);

  localparam logic [CfgWidthW-1:0]  WidthReset  = CfgWidthW'(640);
  localparam logic [CfgHeightW-1:0] HeightReset = CfgHeightW'(480);

  // Direction codes as they arrive on the input.
  localparam logic [CodeW-1:0] CodeDeg0   = CodeW'(0);
  localparam logic [CodeW-1:0] CodeDeg45  = CodeW'(45);
  localparam logic [CodeW-1:0] CodeDeg90  = CodeW'(90);
  localparam logic [CodeW-1:0] CodeDeg135 = CodeW'(135);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Compact direction class kept in the line buffer.
  typedef enum logic [2:0] {
    DIR_VERT    = 3'd0,
    DIR_HORZ    = 3'd1,
    DIR_DIAG45  = 3'd2,
    DIR_DIAG135 = 3'd3,
    DIR_NONE    = 3'd4
  } dir_class_e;

  typedef struct packed {
    logic [MagW-1:0] upper;
    logic [MagW-1:0] middle;
    dir_class_e      dir;
  } line_word_t;

  typedef struct packed {
    logic [MagW-1:0] value;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } result_t;

  function automatic dir_class_e dir_class(input logic [CodeW-1:0] code);
    dir_class_e cls;
    case (code)
      CodeDeg0:   cls = DIR_VERT;
      CodeDeg90:  cls = DIR_HORZ;
      CodeDeg45:  cls = DIR_DIAG45;
      CodeDeg135: cls = DIR_DIAG135;
      default:    cls = DIR_NONE;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

/* design/enms_line_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module enms_line_buf (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [enms_pkg::LineAw-1:0]   rd_addr_i,
  output      enms_pkg::line_word_t          rd_data_o,
  input  wire logic                          wr_en_i,
  input  wire logic [enms_pkg::LineAw-1:0]   wr_addr_i,
  input  wire enms_pkg::line_word_t          wr_data_i,
  output      logic                          clear_done_o
);
  import enms_pkg::*;

  logic [MagW-1:0] upper_mem  [MaxWidth];
  logic [MagW-1:0] middle_mem [MaxWidth];
  dir_class_e      dir_mem    [MaxWidth];

  // The top bit of the sweep counter marks the end of the clearing pass.
  logic [LineAw:0]   clr_q;
  logic              clearing;
  logic              mem_we;
  logic [LineAw-1:0] mem_waddr;
  line_word_t        mem_wdata;
  line_word_t        rd_q;

  assign clearing     = !clr_q[LineAw];
  assign clear_done_o = clr_q[LineAw];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    mem_we    = wr_en_i;
    mem_waddr = wr_addr_i;
    mem_wdata = wr_data_i;
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q[LineAw-1:0];
      mem_wdata = '{upper: '0, middle: '0, dir: DIR_VERT};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      upper_mem[mem_waddr]  <= mem_wdata.upper;
      middle_mem[mem_waddr] <= mem_wdata.middle;
      dir_mem[mem_waddr]    <= mem_wdata.dir;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.upper  <= upper_mem[rd_addr_i];
      rd_q.middle <= middle_mem[rd_addr_i];
      rd_q.dir    <= dir_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

/* design/enms_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module enms_out_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire enms_pkg::result_t             push_data_i,
  output      logic                          valid_o,
  input  wire logic                          ready_i,
  output      enms_pkg::result_t             data_o,
  output      logic [enms_pkg::OutCntW-1:0]  count_o
);
  import enms_pkg::*;

  result_t              entry_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q;
  logic [OutPtrW-1:0]   rd_ptr_q;
  logic [OutCntW-1:0]   count_q;
  logic                 pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  function automatic logic [OutPtrW-1:0] ptr_next(input logic [OutPtrW-1:0] ptr);
    return (ptr == OutPtrW'(OutDepth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* design/edge_non_maximum_suppression.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    grad_magnitude_i, direction_code_i
// out       output     out_valid_o / out_ready_i  suppressed_value_o, pixel_row_o,
//                                                 pixel_col_o, frame_last_o
// cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One pixel beat is taken per clock while in_ready_o is high. A beat reads the line
// buffers at its column in the cycle it is accepted and writes them back in the next,
// where the result is decided and the window shifted; the result is then registered
// into the result queue, from which the out channel presents it.
// After reset the line buffers are swept to zero over all 1024 entries, during which in_ready_o
// stays low. A three-entry result queue lets input flow on while a result waits.

module edge_non_maximum_suppression (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [enms_pkg::MagW-1:0]         grad_magnitude_i,
  input  wire logic [enms_pkg::CodeW-1:0]        direction_code_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [enms_pkg::MagW-1:0]         suppressed_value_o,
  output      logic [enms_pkg::RowW-1:0]         pixel_row_o,
  output      logic [enms_pkg::ColW-1:0]         pixel_col_o,
  output      logic                              frame_last_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [enms_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [enms_pkg::CfgDataW-1:0]     cfg_data_i
);
  import enms_pkg::*;

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [ColW-1:0]       width_m1;
  logic [RowW-1:0]       height_m1;

  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            accept;
  logic            clear_done;

  logic            s1_valid_q;
  logic            s1_emit_q;
  logic [MagW-1:0] s1_mag_q;
  dir_class_e      s1_dir_q;
  logic [LineAw-1:0] s1_addr_q;
  logic [RowW-1:0] s1_row_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_last_q;

  // Two newest window columns, top to bottom, and the direction of the center column.
  logic [MagW-1:0] c1_q [3];
  logic [MagW-1:0] c2_q [3];
  dir_class_e      cdir_q;

  line_word_t      rd_data;
  line_word_t      wr_data;
  result_t         result;
  result_t         out_data;
  logic [OutCntW-1:0] out_count;
  logic [OutCntW:0]   in_flight;
  logic [MagW-1:0] nb1;
  logic [MagW-1:0] nb2;
  logic [MagW-1:0] center;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CfgWidthW-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // Width clamps into the line buffer depth, both sizes to at least three.
  always_comb begin
    if (width_q < CfgWidthW'(3)) begin
      width_m1 = ColW'(2);
    end else if (width_q > CfgWidthW'(MaxWidth)) begin
      width_m1 = ColW'(MaxWidth - 1);
    end else begin
      width_m1 = ColW'(width_q - 1'b1);
    end
    if (height_q < CfgHeightW'(3)) begin
      height_m1 = RowW'(2);
    end else begin
      height_m1 = height_q - 1'b1;
    end
  end

  // Every queued result plus the one about to be decided must fit in the queue.
  assign in_flight  = {1'b0, out_count} + {{OutCntW{1'b0}}, s1_valid_q && s1_emit_q};
  assign in_ready_o = clear_done && (in_flight < (OutCntW + 1)'(OutDepth));
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q >= width_m1) begin
        col_q <= '0;
        row_q <= (row_q >= height_m1) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_emit_q  <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mag_q  <= grad_magnitude_i;
      s1_dir_q  <= dir_class(direction_code_i);
      s1_addr_q <= LineAw'(col_q);
      s1_row_q  <= row_q - 1'b1;
      s1_col_q  <= col_q - 1'b1;
      s1_last_q <= (row_q == height_m1) && (col_q == width_m1);
    end
  end

  // The line shifts up one row at each column it passes.
  assign wr_data = '{upper: rd_data.middle, middle: s1_mag_q, dir: s1_dir_q};

  enms_line_buf u_line_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_addr_i    (LineAw'(col_q)),
    .rd_data_o    (rd_data),
    .wr_en_i      (s1_valid_q),
    .wr_addr_i    (s1_addr_q),
    .wr_data_i    (wr_data),
    .clear_done_o (clear_done)
  );

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      c1_q   <= c2_q;
      c2_q   <= '{rd_data.upper, rd_data.middle, s1_mag_q};
      cdir_q <= rd_data.dir;
    end
  end

  // Window after the shift: left column c1_q, center column c2_q, right column
  // the fresh line buffer data with the incoming pixel at the bottom.
  assign center = c2_q[1];

  always_comb begin
    nb1 = '0;
    nb2 = '0;
    case (cdir_q)
      DIR_VERT: begin
        nb1 = c2_q[0];
        nb2 = c2_q[2];
      end
      DIR_HORZ: begin
        nb1 = c1_q[1];
        nb2 = rd_data.middle;
      end
      DIR_DIAG45: begin
        nb1 = rd_data.upper;
        nb2 = c1_q[2];
      end
      DIR_DIAG135: begin
        nb1 = c1_q[0];
        nb2 = s1_mag_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.value = ((center >= nb1) && (center >= nb2)) ? center : '0;
    result.row   = s1_row_q;
    result.col   = s1_col_q;
    result.last  = s1_last_q;
  end

  enms_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q && s1_emit_q),
    .push_data_i (result),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_data),
    .count_o     (out_count)
  );

  assign suppressed_value_o = out_data.value;
  assign pixel_row_o        = out_data.row;
  assign pixel_col_o        = out_data.col;
  assign frame_last_o       = out_data.last;

endmodule

`default_nettype wire
